### rtl/core/rlewd_pkg.sv
// Shared types and constants for the run-length image window decoder.
// No dependencies. Imported by the controller, the datapath and the top level.
`default_nettype none

package rlewd_pkg;

  // Screen geometry and the planar video layout.
  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 400;
  localparam int unsigned ROW_BYTES     = 80;

  // Field widths fixed by the interface.
  localparam int unsigned COORD_W = 9;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned PLANE_W = 4;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  // Stream byte codes.
  localparam logic [COLOR_W-1:0] RUN_MARK    = 8'd191;
  localparam logic [COLOR_W-1:0] RUN_BASE    = 8'd192;
  localparam logic [COLOR_W-1:0] TRANSPARENT = 8'd255;

  // Video page bases.
  localparam logic [ADDR_W-1:0] PAGE0_BASE = 16'h0000;
  localparam logic [ADDR_W-1:0] PAGE1_BASE = 16'h8000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SELECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_X_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_MIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT  = 3'd7;

  // Reset values of the window size registers.
  localparam logic [COORD_W-1:0] WIN_WIDTH_RESET  = 9'd319;
  localparam logic [COORD_W-1:0] WIN_HEIGHT_RESET = 9'd399;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_MARK,
    ST_FLUSH
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an input word is taken this cycle
    logic step;    // advance one pixel of the current run
    logic mark;    // queue the end marker
    logic flush;   // release the held result as the last of this word
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_run;    // the word on the input would start pixel work
    logic hold_valid;   // a result waits in the holding register
    logic out_free;     // the output register can take a word this cycle
    logic step_finish;  // this step ends the window or the image
    logic count_one;    // this step is the last of the run
  } status_t;

endpackage

`default_nettype wire

### rtl/core/rlewd_ctrl.sv
// Controller state machine of the decoder: sequences accept, pixel steps,
// end marker and flush. Depends on rlewd_pkg.
`default_nettype none

module rlewd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  rlewd_pkg::status_t     status,
  output rlewd_pkg::cmd_t        cmd
);
  import rlewd_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        can_move;

  // The held result can only be displaced when the output register frees up.
  assign can_move = !status.hold_valid || status.out_free;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && status.start_run) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (can_move) begin
          if (status.step_finish) begin
            state_next = ST_MARK;
          end else if (status.count_one) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_MARK: begin
        if (can_move) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (can_move) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_RUN:   cmd.step  = can_move;
      ST_MARK:  cmd.mark  = can_move;
      ST_FLUSH: cmd.flush = can_move;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/rlewd_datapath.sv
// Datapath of the decoder: configuration registers, run and position state,
// the per-pixel window and clip logic, the holding and output registers.
// Depends on rlewd_pkg.
`default_nettype none

module rlewd_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [rlewd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rlewd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [rlewd_pkg::COLOR_W-1:0]        data_byte,
  input  wire logic                                 first_byte,
  input  rlewd_pkg::cmd_t                           cmd,
  output rlewd_pkg::status_t                        status,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      is_pixel,
  output logic [rlewd_pkg::COORD_W-1:0]             screen_x,
  output logic [rlewd_pkg::COORD_W-1:0]             screen_y,
  output logic [rlewd_pkg::COLOR_W-1:0]             pixel_color,
  output logic [rlewd_pkg::ADDR_W-1:0]              vram_offset,
  output logic [rlewd_pkg::PLANE_W-1:0]             plane_enable,
  output logic                                      image_done,
  output logic                                      last_of_run
);
  import rlewd_pkg::*;

  // Configuration registers.
  logic               page_select;
  logic [COORD_W-1:0] dest_x;
  logic [COORD_W-1:0] dest_y;
  logic               mask_enable;
  logic [COORD_W-1:0] win_x_min;
  logic [COORD_W-1:0] win_y_min;
  logic [COORD_W-1:0] win_width;
  logic [COORD_W-1:0] win_height;

  // Decode and position state.
  logic [COUNT_W-1:0] pending_count;
  logic               expect_color;
  logic               finished;
  logic [COUNT_W-1:0] run_count;
  logic [COLOR_W-1:0] run_color;
  logic [COORD_W-1:0] source_col;
  logic [COORD_W-1:0] source_row;
  logic [COORD_W-1:0] window_col;
  logic [COORD_W-1:0] window_row;

  // Holding register: one result is kept back until it is known whether it
  // is the last one caused by the current word.
  logic               hold_valid;
  logic               hold_pixel;
  logic [COORD_W-1:0] hold_x;
  logic [COORD_W-1:0] hold_y;
  logic [COLOR_W-1:0] hold_color;

  // Effective decode state once a first_byte clear is applied.
  logic               eff_finished;
  logic               eff_expect;
  logic [COUNT_W-1:0] eff_pending;

  // Per-step signals.
  logic               start_run;
  logic [COORD_W:0]   win_x_max;
  logic [COORD_W:0]   win_y_max;
  logic               in_window;
  logic [COORD_W:0]   sum_x;
  logic [COORD_W:0]   sum_y;
  logic               visible;
  logic               step_emit;
  logic               win_col_wrap;
  logic               fin_window;
  logic               src_col_wrap;
  logic               fin_source;
  logic               step_finish;
  logic               load_hold;
  logic               push_out;
  logic               push_last;
  logic               out_free;

  // Address of the held result.
  logic [ADDR_W-1:0]  row_addr;
  logic [ADDR_W-1:0]  page_base;
  logic [ADDR_W-1:0]  hold_addr;
  logic [PLANE_W-1:0] hold_plane;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_select <= 1'b0;
      dest_x      <= '0;
      dest_y      <= '0;
      mask_enable <= 1'b0;
      win_x_min   <= '0;
      win_y_min   <= '0;
      win_width   <= WIN_WIDTH_RESET;
      win_height  <= WIN_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PAGE_SELECT: page_select <= cfg_data[0];
        REG_DEST_X:      dest_x      <= cfg_data;
        REG_DEST_Y:      dest_y      <= cfg_data;
        REG_MASK_ENABLE: mask_enable <= cfg_data[0];
        REG_WIN_X_MIN:   win_x_min   <= cfg_data;
        REG_WIN_Y_MIN:   win_y_min   <= cfg_data;
        REG_WIN_WIDTH:   win_width   <= cfg_data;
        REG_WIN_HEIGHT:  win_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A first_byte word clears the decode state before it is looked at.
  assign eff_finished = first_byte ? 1'b0 : finished;
  assign eff_expect   = first_byte ? 1'b0 : expect_color;
  assign eff_pending  = first_byte ? '0 : pending_count;

  // The word starts pixel work if it is a colour with a non-empty run or a
  // literal pixel.
  always_comb begin
    start_run = 1'b0;
    if (!eff_finished) begin
      if (eff_expect) begin
        start_run = (eff_pending != '0);
      end else begin
        start_run = (data_byte <= RUN_MARK);
      end
    end
  end

  // Window membership of the current source position.
  assign win_x_max = {1'b0, win_x_min} + {1'b0, win_width};
  assign win_y_max = {1'b0, win_y_min} + {1'b0, win_height};
  assign in_window = (source_col >= win_x_min) && ({1'b0, source_col} <= win_x_max) &&
                     (source_row >= win_y_min) && ({1'b0, source_row} <= win_y_max);

  // Screen position, clipping and transparency.
  assign sum_x   = {1'b0, window_col} + {1'b0, dest_x};
  assign sum_y   = {1'b0, window_row} + {1'b0, dest_y};
  assign visible = (sum_x < (COORD_W+1)'(SCREEN_WIDTH)) &&
                   (sum_y < (COORD_W+1)'(SCREEN_HEIGHT)) &&
                   !(mask_enable && (run_color == TRANSPARENT));
  assign step_emit = in_window && visible;

  // Position wrap and end conditions.
  assign win_col_wrap = window_col >= win_width;
  assign fin_window   = in_window && win_col_wrap && (window_row >= win_height);
  assign src_col_wrap = source_col >= COORD_W'(SCREEN_WIDTH - 1);
  assign fin_source   = !fin_window && src_col_wrap &&
                        (source_row >= COORD_W'(SCREEN_HEIGHT - 1));
  assign step_finish  = fin_window || fin_source;

  // Result movement between the holding and output registers.
  assign out_free  = !out_valid || out_ready;
  assign load_hold = (cmd.step && step_emit) || cmd.mark;
  assign push_out  = (load_hold || cmd.flush) && hold_valid;
  assign push_last = cmd.flush;

  assign status.start_run   = start_run;
  assign status.hold_valid  = hold_valid;
  assign status.out_free    = out_free;
  assign status.step_finish = step_finish;
  assign status.count_one   = (run_count == COUNT_W'(1));

  // Decode state and run counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= '0;
      expect_color  <= 1'b0;
      finished      <= 1'b0;
      run_count     <= '0;
    end else if (cmd.accept) begin
      if (first_byte) begin
        finished <= 1'b0;
      end
      if (!eff_finished) begin
        if (eff_expect) begin
          expect_color  <= 1'b0;
          pending_count <= '0;
          run_count     <= eff_pending;
        end else if (data_byte > RUN_MARK) begin
          pending_count <= COUNT_W'(data_byte - RUN_BASE);
          expect_color  <= 1'b1;
        end else begin
          // A literal leaves no run pending, which also covers a restart.
          pending_count <= '0;
          expect_color  <= 1'b0;
          run_count     <= COUNT_W'(1);
        end
      end
    end else if (cmd.step) begin
      run_count <= run_count - COUNT_W'(1);
      if (step_finish) begin
        finished <= 1'b1;
      end
    end
  end

  // Colour of the current run.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      run_color <= data_byte;
    end
  end

  // Source and window positions.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_col <= '0;
      source_row <= '0;
      window_col <= '0;
      window_row <= '0;
    end else if (cmd.accept && first_byte) begin
      source_col <= '0;
      source_row <= '0;
      window_col <= '0;
      window_row <= '0;
    end else if (cmd.step) begin
      if (in_window) begin
        if (win_col_wrap) begin
          window_col <= '0;
          window_row <= window_row + COORD_W'(1);
        end else begin
          window_col <= window_col + COORD_W'(1);
        end
      end
      if (!fin_window) begin
        if (src_col_wrap) begin
          source_col <= '0;
          source_row <= source_row + COORD_W'(1);
        end else begin
          source_col <= source_col + COORD_W'(1);
        end
      end
    end
  end

  // Holding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load_hold) begin
      hold_valid <= 1'b1;
    end else if (cmd.flush) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark) begin
      hold_pixel <= 1'b0;
      hold_x     <= '0;
      hold_y     <= '0;
      hold_color <= '0;
    end else if (cmd.step && step_emit) begin
      hold_pixel <= 1'b1;
      hold_x     <= sum_x[COORD_W-1:0];
      hold_y     <= sum_y[COORD_W-1:0];
      hold_color <= run_color;
    end
  end

  // Planar video address of the held result.
  assign row_addr   = ADDR_W'({{(ADDR_W-COORD_W){1'b0}}, hold_y} * ADDR_W'(ROW_BYTES));
  assign page_base  = page_select ? PAGE1_BASE : PAGE0_BASE;
  assign hold_addr  = hold_pixel ?
                      (page_base + row_addr + ADDR_W'(hold_x[COORD_W-1:2])) : '0;
  assign hold_plane = hold_pixel ? (PLANE_W'(1) << hold_x[1:0]) : '0;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_out) begin
      is_pixel     <= hold_pixel;
      screen_x     <= hold_x;
      screen_y     <= hold_y;
      pixel_color  <= hold_color;
      vram_offset  <= hold_addr;
      plane_enable <= hold_plane;
      image_done   <= !hold_pixel;
      last_of_run  <= push_last;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rle_image_window_decoder_core.sv
// Run-length image window decoder top level, built on rlewd_pkg, rlewd_ctrl, rlewd_datapath.
// A literal is accepted, stepped once, then flushed; a colour byte of an n-pixel run is
// accepted, stepped per pixel, then flushed; a run header or an empty run is only accepted.
// The end marker adds a mark step; output stalls can hold a step, the mark or the flush.
// Synchronous reset: configuration returns to its defaults, positions clear.
`default_nettype none

module rle_image_window_decoder_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [rlewd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rlewd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [rlewd_pkg::COLOR_W-1:0]        data_byte,
  input  wire logic                                 first_byte,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      is_pixel,
  output logic [rlewd_pkg::COORD_W-1:0]             screen_x,
  output logic [rlewd_pkg::COORD_W-1:0]             screen_y,
  output logic [rlewd_pkg::COLOR_W-1:0]             pixel_color,
  output logic [rlewd_pkg::ADDR_W-1:0]              vram_offset,
  output logic [rlewd_pkg::PLANE_W-1:0]             plane_enable,
  output logic                                      image_done,
  output logic                                      last_of_run
);
  import rlewd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  rlewd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Position, window and address datapath.
  rlewd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_pixel     (is_pixel),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .pixel_color  (pixel_color),
    .vram_offset  (vram_offset),
    .plane_enable (plane_enable),
    .image_done   (image_done),
    .last_of_run  (last_of_run)
  );

`ifndef NO_ASSERTIONS
  // Nothing may be held back while a new word is being taken.
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !status.hold_valid)
    else $error("holding register occupied while accepting input");

  // The end marker is always the last word of its input byte.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && image_done) |-> (last_of_run && !is_pixel))
    else $error("end marker not flagged as last");

  // A pixel word selects exactly one plane.
  a_plane_onehot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_pixel) |-> $onehot(plane_enable))
    else $error("pixel word without a single plane");

  // A finishing step is followed by the end marker, not by new input.
  a_finish_marks: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.step_finish) |=> !in_ready)
    else $error("input accepted before the end marker");
`endif

endmodule

`default_nettype wire

### test/tb_rle_image_window_decoder_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for rle_image_window_decoder_core: directed table and random
// streams, checked word by word against a behavioural decoder or the table's own words.
// Depends on rlewd_pkg and the decoder RTL only.

module tb_rle_image_window_decoder_core;
  import rlewd_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_WORDS  = 420;
  localparam int unsigned RANDOM_PHASES = 6;

  // One result word as seen on the output port.
  typedef struct packed {
    logic               is_pixel;
    logic [COORD_W-1:0] scr_x;
    logic [COORD_W-1:0] scr_y;
    logic [COLOR_W-1:0] colour;
    logic [ADDR_W-1:0]  vram;
    logic [PLANE_W-1:0] planes;
    logic               done;
    logic               last;
  } pix_word_t;

  // One row of the directed table: a register write or a stream byte.
  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [COLOR_W-1:0]    stream_byte;
    logic                  restart;
    logic                  typed;
    pix_word_t             want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COLOR_W-1:0]    data_byte = '0;
  logic                  first_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  is_pixel;
  logic [COORD_W-1:0]    screen_x;
  logic [COORD_W-1:0]    screen_y;
  logic [COLOR_W-1:0]    pixel_color;
  logic [ADDR_W-1:0]     vram_offset;
  logic [PLANE_W-1:0]    plane_enable;
  logic                  image_done;
  logic                  last_of_run;

  rle_image_window_decoder_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_pixel     (is_pixel),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .pixel_color  (pixel_color),
    .vram_offset  (vram_offset),
    .plane_enable (plane_enable),
    .image_done   (image_done),
    .last_of_run  (last_of_run)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the configuration registers, at their reset values.
  logic        page_sel = 1'b0;
  int unsigned dst_x = 0;
  int unsigned dst_y = 0;
  logic        mask_on = 1'b0;
  int unsigned wx0 = 0;
  int unsigned wy0 = 0;
  int unsigned wlast_col = WIN_WIDTH_RESET;
  int unsigned wlast_row = WIN_HEIGHT_RESET;

  // Decoder progress, cleared by reset or by a restart byte.
  int unsigned run_left = 0;
  logic        want_colour = 1'b0;
  int unsigned src_col = 0;
  int unsigned src_row = 0;
  int unsigned win_col = 0;
  int unsigned win_row = 0;
  logic        decode_over = 1'b0;

  // Words produced by the latest byte, and every word still owed by the block.
  pix_word_t step_words[$];
  pix_word_t pending_words[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  int err_count = 0;
  int words_in = 0;
  int words_out = 0;
  int markers_seen = 0;
  int results_made = 0;
  int reg_writes = 0;

  // Builds a pixel word at screen position (x, y) with the current page.
  function automatic pix_word_t place_pixel(int unsigned x, int unsigned y,
                                            logic [COLOR_W-1:0] c);
    pix_word_t w;
    w          = '0;
    w.is_pixel = 1'b1;
    w.scr_x    = x[COORD_W-1:0];
    w.scr_y    = y[COORD_W-1:0];
    w.colour   = c;
    w.vram     = (page_sel ? PAGE1_BASE : PAGE0_BASE) + 16'(ROW_BYTES * y + x / 4);
    w.planes   = 4'b0001 << (x % 4);
    return w;
  endfunction

  // Decodes one stream byte and leaves the words it causes in step_words.
  task automatic decode_byte(input logic [COLOR_W-1:0] b, input logic restart);
    int unsigned n;
    int unsigned sx;
    int unsigned sy;
    logic [COLOR_W-1:0] c;
    pix_word_t marker;
    step_words.delete();
    if (restart) begin
      run_left    = 0;
      want_colour = 1'b0;
      src_col     = 0;
      src_row     = 0;
      win_col     = 0;
      win_row     = 0;
      decode_over = 1'b0;
    end
    if (decode_over) return;
    if (want_colour) begin
      want_colour = 1'b0;
      n           = run_left;
      run_left    = 0;
      c           = b;
    end else if (b > RUN_MARK) begin
      run_left    = b - RUN_BASE;
      want_colour = 1'b1;
      return;
    end else begin
      n = 1;
      c = b;
    end
    for (int unsigned j = 0; j < n; j++) begin
      if (src_col >= wx0 && src_col <= wx0 + wlast_col &&
          src_row >= wy0 && src_row <= wy0 + wlast_row) begin
        sx = win_col + dst_x;
        sy = win_row + dst_y;
        if (sx < SCREEN_WIDTH && sy < SCREEN_HEIGHT && !(c == TRANSPARENT && mask_on))
          step_words.push_back(place_pixel(sx, sy, c));
        if (win_col >= wlast_col) begin
          win_col = 0;
          win_row++;
          if (win_row > wlast_row) begin
            decode_over = 1'b1;
            break;
          end
        end else begin
          win_col++;
        end
      end
      if (src_col >= SCREEN_WIDTH - 1) begin
        src_col = 0;
        src_row++;
        if (src_row > SCREEN_HEIGHT - 1) begin
          decode_over = 1'b1;
          break;
        end
      end else begin
        src_col++;
      end
    end
    if (decode_over) begin
      marker      = '0;
      marker.done = 1'b1;
      step_words.push_back(marker);
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
  endtask

  // Offers one byte, waits for it to be taken and records what it should produce.
  task automatic send_word(input logic [COLOR_W-1:0] b, input logic restart,
                           input logic typed, input pix_word_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    first_byte <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, restart);
    if (typed) begin
      pending_words.push_back(want);
      results_made++;
    end else begin
      foreach (step_words[k]) pending_words.push_back(step_words[k]);
      results_made += step_words.size();
    end
    words_in++;
    @(negedge clk);
  endtask

  // Writes one register and mirrors it in the shadow copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_PAGE_SELECT: page_sel  = val[0];
      REG_DEST_X:      dst_x     = val & 9'h1FF;
      REG_DEST_Y:      dst_y     = val & 9'h1FF;
      REG_MASK_ENABLE: mask_on   = val[0];
      REG_WIN_X_MIN:   wx0       = val & 9'h1FF;
      REG_WIN_Y_MIN:   wy0       = val & 9'h1FF;
      REG_WIN_WIDTH:   wlast_col = val & 9'h1FF;
      REG_WIN_HEIGHT:  wlast_row = val & 9'h1FF;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Stops offering, waits for every owed word, then lets any silent work finish.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int unsigned pick_value(int unsigned hi);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // Mostly run pairs and literals; restarts mostly once the image has ended.
  task automatic next_random(output logic [COLOR_W-1:0] b, output logic restart);
    int unsigned roll;
    restart = decode_over ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 199) == 0);
    roll    = $urandom_range(0, 99);
    if (want_colour && !restart)
      b = ($urandom_range(0, 3) == 0) ? TRANSPARENT : 8'($urandom_range(0, 255));
    else if (roll < 45)
      b = $urandom_range(0, 1) ? 8'($urandom_range(240, 255)) : 8'($urandom_range(192, 255));
    else if (roll < 90)
      b = 8'($urandom_range(0, 191));
    else
      b = 8'($urandom_range(0, 255));
  endtask

  function automatic pix_word_t pix(int unsigned x, int unsigned y, logic [COLOR_W-1:0] c,
                                    logic [ADDR_W-1:0] vram, logic [PLANE_W-1:0] planes);
    pix_word_t w;
    w          = '0;
    w.is_pixel = 1'b1;
    w.scr_x    = x[COORD_W-1:0];
    w.scr_y    = y[COORD_W-1:0];
    w.colour   = c;
    w.vram     = vram;
    w.planes   = planes;
    w.last     = 1'b1;
    return w;
  endfunction

  function automatic plan_row_t byte_row(logic [COLOR_W-1:0] b, logic restart);
    plan_row_t r;
    r             = '0;
    r.stream_byte = b;
    r.restart     = restart;
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic [COLOR_W-1:0] b, logic restart, pix_word_t w);
    plan_row_t r;
    r       = byte_row(b, restart);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    plan_row_t r;
    r         = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val[CFG_DATA_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Each accepted result word is compared with the oldest one owed.
  always @(posedge clk) begin : result_check
    pix_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: result word with nothing expected (is_pixel %0d, x %0d, y %0d)",
                 $time, is_pixel, screen_x, screen_y);
        err_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("is_pixel", want.is_pixel, is_pixel);
        check_field("screen_x", want.scr_x, screen_x);
        check_field("screen_y", want.scr_y, screen_y);
        check_field("pixel_color", want.colour, pixel_color);
        check_field("vram_offset", want.vram, vram_offset);
        check_field("plane_enable", want.planes, plane_enable);
        check_field("image_done", want.done, image_done);
        check_field("last_of_run", want.last, last_of_run);
      end
      words_out++;
      if (image_done) markers_seen++;
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  initial begin : watchdog
    int quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no word moved for %0d cycles, %0d results still owed",
             $time, QUIET_LIMIT, pending_words.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan[$];
    logic [COLOR_W-1:0] b;
    logic restart;
    bit settled;
    int send_idle_of[4];
    int recv_stall_of[4];

    send_idle_of  = '{0, 54, 0, 34};
    recv_stall_of = '{0, 0, 54, 34};

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed table, reset configuration first.
    plan.push_back(typed_row(8'h00, 1'b1, pix(0, 0, 8'h00, 16'h0000, 4'b0001)));
    plan.push_back(typed_row(8'hBF, 1'b0, pix(1, 0, 8'hBF, 16'h0000, 4'b0010)));
    // A zero-length run yields nothing and leaves the position alone.
    plan.push_back(byte_row(RUN_BASE, 1'b0));
    plan.push_back(byte_row(8'h5A, 1'b0));
    // Longest run.
    plan.push_back(byte_row(8'hFF, 1'b0));
    plan.push_back(byte_row(8'hA5, 1'b0));
    // Transparent pixel is skipped but still moves the position.
    plan.push_back(reg_row(REG_MASK_ENABLE, 1));
    plan.push_back(byte_row(8'hC1, 1'b0));
    plan.push_back(byte_row(TRANSPARENT, 1'b0));
    plan.push_back(byte_row(8'h80, 1'b0));
    // Far corner of the second page, then a pixel clipped off the right edge.
    plan.push_back(reg_row(REG_PAGE_SELECT, 1));
    plan.push_back(reg_row(REG_DEST_X, 318));
    plan.push_back(reg_row(REG_DEST_Y, 399));
    plan.push_back(typed_row(8'h00, 1'b1, pix(318, 399, 8'h00, 16'hFCFF, 4'b0100)));
    plan.push_back(typed_row(8'hBF, 1'b0, pix(319, 399, 8'hBF, 16'hFCFF, 4'b1000)));
    plan.push_back(byte_row(8'h33, 1'b0));
    // A two-pixel window ends part way through a run; later bytes are ignored.
    plan.push_back(reg_row(REG_MASK_ENABLE, 0));
    plan.push_back(reg_row(REG_PAGE_SELECT, 0));
    plan.push_back(reg_row(REG_DEST_X, 0));
    plan.push_back(reg_row(REG_DEST_Y, 0));
    plan.push_back(reg_row(REG_WIN_X_MIN, 5));
    plan.push_back(reg_row(REG_WIN_Y_MIN, 0));
    plan.push_back(reg_row(REG_WIN_WIDTH, 1));
    plan.push_back(reg_row(REG_WIN_HEIGHT, 0));
    plan.push_back(byte_row(8'hFF, 1'b1));
    plan.push_back(byte_row(8'h07, 1'b0));
    plan.push_back(byte_row(8'h12, 1'b0));
    plan.push_back(byte_row(8'hFF, 1'b0));
    // Full window again; a restart drops a pending run; a colour above 191.
    plan.push_back(reg_row(REG_WIN_X_MIN, 0));
    plan.push_back(reg_row(REG_WIN_WIDTH, 319));
    plan.push_back(reg_row(REG_WIN_HEIGHT, 399));
    plan.push_back(typed_row(8'h40, 1'b1, pix(0, 0, 8'h40, 16'h0000, 4'b0001)));
    plan.push_back(byte_row(8'hC5, 1'b0));
    plan.push_back(byte_row(8'h22, 1'b1));
    plan.push_back(byte_row(8'hC3, 1'b0));
    plan.push_back(byte_row(8'hC0, 1'b0));

    settled = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!settled) settle_block();
        settled = 1'b1;
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_word(plan[i].stream_byte, plan[i].restart, plan[i].typed, plan[i].want);
        settled = 1'b0;
      end
    end

    // Random phases, each with a fresh configuration and one of four idling mixes.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_block();
      idle_pct  = send_idle_of[phase % 4];
      stall_pct = recv_stall_of[phase % 4];
      write_reg(REG_PAGE_SELECT, $urandom_range(0, 1));
      write_reg(REG_DEST_X, pick_value(SCREEN_WIDTH - 1));
      write_reg(REG_DEST_Y, pick_value(SCREEN_HEIGHT - 1));
      write_reg(REG_MASK_ENABLE, $urandom_range(0, 1));
      write_reg(REG_WIN_X_MIN, pick_value(SCREEN_WIDTH - 1));
      write_reg(REG_WIN_Y_MIN, ($urandom_range(0, 3) < 3) ? $urandom_range(0, 2)
                                                          : pick_value(SCREEN_HEIGHT - 1));
      write_reg(REG_WIN_WIDTH, pick_value(SCREEN_WIDTH - 1));
      write_reg(REG_WIN_HEIGHT, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                                            : pick_value(SCREEN_HEIGHT - 1));
      // In the first phase, the receiver holds off while the sender keeps offering.
      if (phase == 0) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_WORDS / RANDOM_PHASES; n++) begin
        next_random(b, restart);
        send_word(b, restart, 1'b0, '0);
      end
    end

    settle_block();
    $display("Run covered %0d stream words, %0d of %0d owed result words, %0d end markers,",
             words_in, words_out, results_made, markers_seen);
    $display("over %0d register writes, four idling mixes and a long output hold-off.",
             reg_writes);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
rtl/core/rlewd_pkg.sv
rtl/core/rlewd_ctrl.sv
rtl/core/rlewd_datapath.sv
rtl/core/rle_image_window_decoder_core.sv
test/tb_rle_image_window_decoder_core.sv
